// ===== sv/ddfp_pkg.sv =====
package ddfp_pkg;

	// Delimiters and digit range
	localparam logic [7:0] GROUP_SEP = 8'h5F;
	localparam logic [7:0] SUB_SEP   = 8'h2C;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Prescaler reduction
	localparam logic [31:0] REDUCE_STEP = 32'd65335;
	localparam logic [31:0] LOW_LIMIT   = 32'd65535;
	// ceil(x / D) = floor((x + D - 1) / D), x = v - LOW_LIMIT, so y = v - Y_OFFSET
	localparam logic [31:0] Y_OFFSET    = LOW_LIMIT - (REDUCE_STEP - 32'd1);
	// low = (y mod D) + Y_OFFSET
	localparam int          RECIP_SHIFT = 47;
	localparam logic [31:0] RECIP_M     = 32'((64'd1 << RECIP_SHIFT) / 64'd65335);
	localparam int          Q_W         = 17;
	localparam int          R_W         = 18;

	// Seen mask bit for group 2
	localparam int SEEN_C = 4;

	typedef struct packed {
		logic [7:0] byte_req;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [15:0] presc_a_low;
		logic [15:0] presc_a_overflow;
		logic [15:0] value_a;
		logic [15:0] presc_b_low;
		logic [15:0] presc_b_overflow;
		logic [15:0] value_b;
		logic [15:0] value_c;
		logic        complete;
	} out_word_t;

	// Parser accumulators captured at end of message
	typedef struct packed {
		logic [31:0] presc_a;
		logic [15:0] value_a;
		logic [31:0] presc_b;
		logic [15:0] value_b;
		logic [15:0] value_c;
		logic        complete;
	} snap_t;

	// Stage load enables for the reduction pipe
	typedef struct packed {
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

// ===== sv/ddfp_parse.sv =====
module ddfp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  ddfp_pkg::in_word_t word,
	output ddfp_pkg::snap_t   snap
);
	import ddfp_pkg::*;

	logic        at_start_q, at_start_d;
	logic [1:0]  gi_q, gi_d;
	logic [1:0]  si_q, si_d;
	logic        gne_q, gne_d;
	logic        sne_q, sne_d;
	logic        stop_q, stop_d;
	logic [4:0]  mask_q, mask_d;
	logic [31:0] pa_q, pa_d, pb_q, pb_d;
	logic [15:0] va_q, va_d, vb_q, vb_d, vc_q, vc_d;

	logic        digit;
	logic [3:0]  dval;
	logic [31:0] pa_step, pb_step;
	logic [15:0] va_step, vb_step, vc_step;

	// Digit decode and times-ten-plus-digit candidates
	assign digit   = (word.byte_req >= CHAR_ZERO) && (word.byte_req <= CHAR_NINE);
	assign dval    = word.byte_req[3:0];
	assign pa_step = (pa_q << 3) + (pa_q << 1) + {28'd0, dval};
	assign pb_step = (pb_q << 3) + (pb_q << 1) + {28'd0, dval};
	assign va_step = (va_q << 3) + (va_q << 1) + {12'd0, dval};
	assign vb_step = (vb_q << 3) + (vb_q << 1) + {12'd0, dval};
	assign vc_step = (vc_q << 3) + (vc_q << 1) + {12'd0, dval};

	// Next state for one ordinary byte
	always_comb begin
		at_start_d = at_start_q;
		gi_d       = gi_q;
		si_d       = si_q;
		gne_d      = gne_q;
		sne_d      = sne_q;
		stop_d     = stop_q;
		mask_d     = mask_q;
		pa_d       = pa_q;
		pb_d       = pb_q;
		va_d       = va_q;
		vb_d       = vb_q;
		vc_d       = vc_q;
		if (at_start_q) begin
			at_start_d = 1'b0;
		end else if (word.byte_req == GROUP_SEP) begin
			if (gne_q && (gi_q != 2'd3))
				gi_d = gi_q + 2'd1;
			gne_d  = 1'b0;
			si_d   = 2'd0;
			sne_d  = 1'b0;
			stop_d = 1'b0;
		end else begin
			gne_d = 1'b1;
			if (gi_q < 2'd2) begin
				if (word.byte_req == SUB_SEP) begin
					if (sne_q && (si_q != 2'd3))
						si_d = si_q + 2'd1;
					sne_d  = 1'b0;
					stop_d = 1'b0;
				end else begin
					sne_d = 1'b1;
					if (si_q < 2'd2) begin
						mask_d[{1'b0, gi_q[0], si_q[0]}] = 1'b1;
						if (!digit) begin
							stop_d = 1'b1;
						end else if (!stop_q) begin
							case ({gi_q[0], si_q[0]})
								2'b00:   pa_d = pa_step;
								2'b01:   va_d = va_step;
								2'b10:   pb_d = pb_step;
								default: vb_d = vb_step;
							endcase
						end
					end
				end
			end else if (gi_q == 2'd2) begin
				mask_d[SEEN_C] = 1'b1;
				if (!digit)
					stop_d = 1'b1;
				else if (!stop_q)
					vc_d = vc_step;
			end
		end
	end

	// State registers; the last byte restarts the parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			gi_q       <= 2'd0;
			si_q       <= 2'd0;
			gne_q      <= 1'b0;
			sne_q      <= 1'b0;
			stop_q     <= 1'b0;
			mask_q     <= 5'd0;
			pa_q       <= 32'd0;
			pb_q       <= 32'd0;
			va_q       <= 16'd0;
			vb_q       <= 16'd0;
			vc_q       <= 16'd0;
		end else if (take) begin
			if (word.last) begin
				at_start_q <= 1'b1;
				gi_q       <= 2'd0;
				si_q       <= 2'd0;
				gne_q      <= 1'b0;
				sne_q      <= 1'b0;
				stop_q     <= 1'b0;
				mask_q     <= 5'd0;
				pa_q       <= 32'd0;
				pb_q       <= 32'd0;
				va_q       <= 16'd0;
				vb_q       <= 16'd0;
				vc_q       <= 16'd0;
			end else begin
				at_start_q <= at_start_d;
				gi_q       <= gi_d;
				si_q       <= si_d;
				gne_q      <= gne_d;
				sne_q      <= sne_d;
				stop_q     <= stop_d;
				mask_q     <= mask_d;
				pa_q       <= pa_d;
				pb_q       <= pb_d;
				va_q       <= va_d;
				vb_q       <= vb_d;
				vc_q       <= vc_d;
			end
		end
	end

	// Current accumulators as seen by the end-of-message capture
	assign snap.presc_a  = pa_q;
	assign snap.value_a  = va_q;
	assign snap.presc_b  = pb_q;
	assign snap.value_b  = vb_q;
	assign snap.value_c  = vc_q;
	assign snap.complete = (mask_q == 5'h1F);

endmodule

// ===== sv/ddfp_reduce.sv =====
module ddfp_reduce (
	input  logic              clk,
	input  ddfp_pkg::pipe_en_t en,
	input  logic [31:0]       presc_s2,
	output logic [15:0]       low,
	output logic [15:0]       ovf
);
	import ddfp_pkg::*;

	logic [31:0]      y;
	logic [63:0]      prod_s3;
	logic [31:0]      y_s3;
	logic             small_s3;
	logic [15:0]      vlow_s3;
	logic [Q_W-1:0]   q0;
	logic [31:0]      r0_full;
	logic [Q_W-1:0]   q0_s4;
	logic [R_W-1:0]   r0_s4;
	logic             small_s4;
	logic [15:0]      vlow_s4;
	logic             corr;
	logic [Q_W-1:0]   q_fix;
	logic [R_W-1:0]   r_fix;

	// Stage 3: reciprocal multiply, q estimate = (y * M) >> 47
	assign y = presc_s2 - Y_OFFSET;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3  <= {32'd0, y} * {32'd0, RECIP_M};
			y_s3     <= y;
			small_s3 <= (presc_s2 <= LOW_LIMIT);
			vlow_s3  <= presc_s2[15:0];
		end
	end

	// Stage 4: remainder of the estimate, at most one step short
	assign q0      = prod_s3[RECIP_SHIFT +: Q_W];
	assign r0_full = y_s3 - 32'({{(32-Q_W){1'b0}}, q0} * REDUCE_STEP);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			q0_s4    <= q0;
			r0_s4    <= r0_full[R_W-1:0];
			small_s4 <= small_s3;
			vlow_s4  <= vlow_s3;
		end
	end

	// Final correction step and small-value bypass
	assign corr  = (r0_s4 >= R_W'(REDUCE_STEP));
	assign q_fix = q0_s4 + {{(Q_W-1){1'b0}}, corr};
	assign r_fix = corr ? (r0_s4 - R_W'(REDUCE_STEP)) : r0_s4;
	assign low   = small_s4 ? vlow_s4 : 16'(r_fix + R_W'(Y_OFFSET));
	assign ovf   = small_s4 ? 16'd0 : q_fix[15:0];

endmodule

// ===== sv/delimited_decimal_field_parser_core.sv =====
// A last word reaches rsp through capture, stages 3 and 4 and the output register.
// Throughput: one byte word per cycle; the parser state updates once per byte taken.
// Only a last word waits, and only while all four stages behind the parser are full.
// Reset: arst_n clears the parser to the start of a message and empties all stages.
module delimited_decimal_field_parser_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  ddfp_pkg::in_word_t   req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output ddfp_pkg::out_word_t  rsp
);
	import ddfp_pkg::*;

	logic      v1_q, v2_q, v3_q, v4_q;
	in_word_t  word_s1;
	snap_t     snap;
	snap_t     snap_s2, snap_s3, snap_s4;
	logic      adv_out, en2, en3, en4, s1_go;
	pipe_en_t  pen;
	logic [15:0] a_low, a_ovf, b_low, b_ovf;
	out_word_t rsp_q;
	logic      rsp_valid_q;

	// Stage advance chain from the output register back
	assign adv_out   = !rsp_valid_q || rsp_ready;
	assign en4       = !v4_q || adv_out;
	assign en3       = !v3_q || en4;
	assign en2       = !v2_q || en3;
	assign s1_go     = v1_q && (!word_s1.last || en2);
	assign req_ready = !v1_q || s1_go;
	assign pen.s3    = en3;
	assign pen.s4    = en4;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (req_ready) begin
			v1_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			word_s1 <= req;
	end

	ddfp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (s1_go),
		.word   (word_s1),
		.snap   (snap)
	);

	// Valid bits of the capture and reduction stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en2)
				v2_q <= s1_go && word_s1.last;
			if (en3)
				v3_q <= v2_q;
			if (en4)
				v4_q <= v3_q;
		end
	end

	// Captured values ride alongside the reduction
	always_ff @(posedge clk) begin
		if (en2 && s1_go && word_s1.last)
			snap_s2 <= snap;
		if (en3)
			snap_s3 <= snap_s2;
		if (en4)
			snap_s4 <= snap_s3;
	end

	ddfp_reduce u_reduce_a (
		.clk      (clk),
		.en       (pen),
		.presc_s2 (snap_s2.presc_a),
		.low      (a_low),
		.ovf      (a_ovf)
	);

	ddfp_reduce u_reduce_b (
		.clk      (clk),
		.en       (pen),
		.presc_s2 (snap_s2.presc_b),
		.low      (b_low),
		.ovf      (b_ovf)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_out) begin
			rsp_valid_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v4_q) begin
			rsp_q.presc_a_low      <= a_low;
			rsp_q.presc_a_overflow <= a_ovf;
			rsp_q.value_a          <= snap_s4.value_a;
			rsp_q.presc_b_low      <= b_low;
			rsp_q.presc_b_overflow <= b_ovf;
			rsp_q.value_b          <= snap_s4.value_b;
			rsp_q.value_c          <= snap_s4.value_c;
			rsp_q.complete         <= snap_s4.complete;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Input stalls only behind a last word with every later stage full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (v1_q && word_s1.last && v2_q && v3_q && v4_q && rsp_valid_q))
		else $error("input stalled with room in the pipe");

	// A blocked stage 4 word is not lost
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_q && !adv_out) |=> v4_q)
		else $error("stage 4 word dropped while blocked");

	// A stage 4 word that moves on shows up as a result
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_q && adv_out) |=> rsp_valid_q)
		else $error("stage 4 word did not reach the output");

endmodule
